// ----- sv/sfsd_pkg.sv -----
// Shared types and constants for the sync frame steering decoder.
// No dependencies; imported by every other file of the block but sfsd_if.
package sfsd_pkg;

   localparam int SYNC_LENGTH_DEFAULT = 4;
   localparam int PAYLOAD_BYTES       = 6;
   localparam int STORE_DEPTH         = 5;

   localparam logic [7:0] SYNC_BYTE = 8'h1F;

   localparam logic [15:0]        ANGLE_SLOPE_RESET = 16'd16734;
   localparam logic signed [15:0] FAR_LIMIT_RESET   = 16'sd1200;
   localparam logic signed [15:0] NEAR_LIMIT_RESET  = 16'sd800;

   typedef enum logic [2:0] {
      MOVE_FORWARD = 3'd0,
      MOVE_BACK    = 3'd1,
      MOVE_LEFT    = 3'd2,
      MOVE_RIGHT   = 3'd3,
      MOVE_HALT    = 3'd4
   } route_type;

   typedef enum logic [1:0] {
      CSR_ANGLE_SLOPE = 2'd0,
      CSR_FAR_LIMIT   = 2'd1,
      CSR_NEAR_LIMIT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        angle_slope;
      logic signed [15:0] far_limit;
      logic signed [15:0] near_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } frame_type;

endpackage

// ----- sv/sfsd_if.sv -----
// Channel interfaces: received bytes, route results and register writes.
// No dependencies.
interface sfsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfsd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         route;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;

   modport source (output valid, output route, output pos_x, output pos_y, output pos_z,
                   input ready);
   modport sink   (input valid, input route, input pos_x, input pos_y, input pos_z,
                   output ready);
endinterface

interface sfsd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/sfsd_framer.sv -----
// Sync hunt and payload capture; registers one decoded frame per completed frame.
// Depends on sfsd_pkg.
module sfsd_framer
   import sfsd_pkg::*;
#(
   parameter int SYNC_LENGTH = SYNC_LENGTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   output logic       byte_ready,
   input  logic [7:0] rx_byte,
   output logic       frame_valid,
   input  logic       frame_ready,
   output frame_type  frame
);

   localparam int LAST   = SYNC_LENGTH + PAYLOAD_BYTES - 1;
   localparam int POS_W  = $clog2(LAST + 1);
   localparam int SLOT_W = $clog2(STORE_DEPTH);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] slot_full;
   logic [SLOT_W-1:0] slot;
   logic [7:0]       store_ff [STORE_DEPTH];
   logic             frame_vld_ff, frame_vld_in;
   frame_type        frame_ff;
   logic             accept, store_wr, frame_load;

   assign byte_ready  = !frame_vld_ff || frame_ready;
   assign accept      = byte_valid && byte_ready;
   assign slot_full   = pos_ff - POS_W'(SYNC_LENGTH);
   assign slot        = slot_full[SLOT_W-1:0];
   assign frame_valid = frame_vld_ff;
   assign frame       = frame_ff;

   always_comb begin
      pos_in     = pos_ff;
      store_wr   = 1'b0;
      frame_load = 1'b0;
      if (accept) begin
         priority if (pos_ff < POS_W'(SYNC_LENGTH)) begin
            pos_in = (rx_byte == SYNC_BYTE) ? pos_ff + 1'b1 : '0;
         end else if (pos_ff < POS_W'(LAST)) begin
            pos_in   = pos_ff + 1'b1;
            store_wr = 1'b1;
         end else begin
            pos_in     = '0;
            frame_load = (pos_ff == POS_W'(LAST));
         end
      end
      if (frame_load) begin
         frame_vld_in = 1'b1;
      end else if (frame_ready) begin
         frame_vld_in = 1'b0;
      end else begin
         frame_vld_in = frame_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         frame_vld_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         frame_vld_ff <= frame_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (store_wr && slot == SLOT_W'(i)) begin
            store_ff[i] <= rx_byte;
         end
      end
      if (frame_load) begin
         frame_ff.x <= {store_ff[1], store_ff[0]};
         frame_ff.y <= {store_ff[3], store_ff[2]};
         frame_ff.z <= {rx_byte, store_ff[4]};
      end
   end

endmodule

// ----- sv/sfsd_route.sv -----
// Route decision by cross-multiplied slope test and z limits, into the result register.
// Depends on sfsd_pkg.
module sfsd_route
   import sfsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       frame_valid,
   output logic       frame_ready,
   input  frame_type  frame,
   sfsd_rsp_if.source rsp_chan
);

   logic               out_vld_ff, out_vld_in;
   route_type          route_ff, route_in;
   frame_type          frame_ff;
   logic signed [16:0] slope_s;
   logic signed [33:0] lhs, rhs, rhs_neg;
   logic               z_pos, z_neg, right, left, load;

   assign frame_ready = !out_vld_ff || rsp_chan.ready;
   assign load        = frame_valid && frame_ready;

   assign slope_s = $signed({1'b0, cfg.angle_slope});
   assign lhs     = {{2{frame.x[15]}}, frame.x, 16'h0000};
   assign rhs     = slope_s * frame.z;
   assign rhs_neg = -rhs;
   assign z_neg   = frame.z[15];
   assign z_pos   = !frame.z[15] && (frame.z != 16'sd0);

   always_comb begin
      priority if (z_pos) begin
         right = lhs > rhs;
         left  = lhs < rhs_neg;
      end else if (z_neg) begin
         right = lhs < rhs;
         left  = lhs > rhs_neg;
      end else begin
         right = !frame.x[15] && (frame.x != 16'sd0);
         left  = frame.x[15];
      end
      priority if (right) begin
         route_in = MOVE_RIGHT;
      end else if (left) begin
         route_in = MOVE_LEFT;
      end else if (frame.z > cfg.far_limit) begin
         route_in = MOVE_BACK;
      end else if (frame.z < cfg.near_limit) begin
         route_in = MOVE_FORWARD;
      end else begin
         route_in = MOVE_HALT;
      end
      if (load) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         route_ff <= route_in;
         frame_ff <= frame;
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.route = route_ff;
   assign rsp_chan.pos_x = frame_ff.x;
   assign rsp_chan.pos_y = frame_ff.y;
   assign rsp_chan.pos_z = frame_ff.z;

endmodule

// ----- sv/sync_frame_steering_decoder.sv -----
// Top level of the sync frame steering decoder: register file, framer and route stage.
// Depends on sfsd_pkg, sfsd_if, sfsd_framer and sfsd_route.
//
//  channel    dir   payload                          transaction
//  req_chan   in    rx_byte[7:0]                     one received byte
//  rsp_chan   out   route[2:0], pos_x/y/z[15:0]      one decision per frame
//  csr_chan   in    index[1:0], data[15:0]           one register write
//
// One byte per cycle is accepted while req_chan is not stalled; a result passes through the
// framer register, then the result register holding the 17x16 multiply and compares.
// Synchronous reset returns to the sync hunt and loads default thresholds.
// A stalled result holds one frame in the framer register before req_chan stalls.
module sync_frame_steering_decoder
   import sfsd_pkg::*;
#(
   parameter int SYNC_LENGTH = SYNC_LENGTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   sfsd_req_if.sink   req_chan,
   sfsd_rsp_if.source rsp_chan,
   sfsd_csr_if.sink   csr_chan
);

   cfg_type   cfg_ff;
   logic      frame_valid, frame_ready;
   frame_type frame;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_slope <= ANGLE_SLOPE_RESET;
         cfg_ff.far_limit   <= FAR_LIMIT_RESET;
         cfg_ff.near_limit  <= NEAR_LIMIT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_ANGLE_SLOPE: cfg_ff.angle_slope <= csr_chan.data;
            CSR_FAR_LIMIT:   cfg_ff.far_limit   <= csr_chan.data;
            CSR_NEAR_LIMIT:  cfg_ff.near_limit  <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   sfsd_framer #(
      .SYNC_LENGTH (SYNC_LENGTH)
   ) u_framer (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_chan.valid),
      .byte_ready  (req_chan.ready),
      .rx_byte     (req_chan.rx_byte),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame)
   );

   sfsd_route u_route (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for sync_frame_steering_decoder: byte stream in, route decisions out.
// Depends on sfsd_pkg, sfsd_if and the top level; a scoreboard predicts every frame decision and
// compares it with the result channel, while plain tasks drive bytes and register writes.
module testbench
   import sfsd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SYNC_LEN      = SYNC_LENGTH_DEFAULT;
   localparam int          LAST_SLOT     = SYNC_LEN + PAYLOAD_BYTES - 1;
   localparam logic [1:0]  CSR_SPARE     = 2'd3;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned LIMIT_CYCLES  = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_FRAMES  = 20;

   typedef struct {
      route_type route;
      frame_type pos;
   } steer_result_type;

   class route_predictor;
      logic [15:0]        slope;
      logic signed [15:0] far_limit;
      logic signed [15:0] near_limit;
      int unsigned        position;
      logic [7:0]         store [STORE_DEPTH];
      steer_result_type   routes_due [$];
      int unsigned        mismatches;

      function new();
         slope      = ANGLE_SLOPE_RESET;
         far_limit  = FAR_LIMIT_RESET;
         near_limit = NEAR_LIMIT_RESET;
         position   = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] value);
         if (idx == CSR_ANGLE_SLOPE)
            slope = value;
         else if (idx == CSR_FAR_LIMIT)
            far_limit = value;
         else if (idx == CSR_NEAR_LIMIT)
            near_limit = value;
      endfunction

      function route_type pick_route(logic signed [15:0] x, logic signed [15:0] z);
         longint xl, zl, sl, lhs, rhs;
         bit     right, left;
         xl  = x;
         zl  = z;
         sl  = slope;
         lhs = xl * 65536;
         rhs = sl * zl;
         if (zl > 0) begin
            right = lhs > rhs;
            left  = lhs < -rhs;
         end else if (zl < 0) begin
            right = lhs < rhs;
            left  = lhs > -rhs;
         end else begin
            right = xl > 0;
            left  = xl < 0;
         end
         if (right)
            return MOVE_RIGHT;
         if (left)
            return MOVE_LEFT;
         if (z > far_limit)
            return MOVE_BACK;
         if (z < near_limit)
            return MOVE_FORWARD;
         return MOVE_HALT;
      endfunction

      function void take_byte(logic [7:0] b);
         steer_result_type r;
         if (position < SYNC_LEN) begin
            position = (b == SYNC_BYTE) ? position + 1 : 0;
         end else if (position < LAST_SLOT) begin
            store[position - SYNC_LEN] = b;
            position++;
         end else begin
            position  = 0;
            r.pos.x   = {store[1], store[0]};
            r.pos.y   = {store[3], store[2]};
            r.pos.z   = {b, store[4]};
            r.route   = pick_route(r.pos.x, r.pos.z);
            routes_due.push_back(r);
         end
      endfunction

      function void check_route(logic [2:0] route, logic signed [15:0] x,
                                logic signed [15:0] y, logic signed [15:0] z);
         steer_result_type e;
         if (routes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: route %0d x %0d y %0d z %0d", route, x, y, z);
            return;
         end
         e = routes_due.pop_front();
         if (route !== e.route || x !== e.pos.x || y !== e.pos.y || z !== e.pos.z) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: route %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d (exp/got)",
                        e.route, route, e.pos.x, x, e.pos.y, y, e.pos.z, z);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycle_count;
   bit          hold_request;
   bit          req_eager;
   int unsigned req_run_left;
   bit          req_quiet;
   int unsigned rsp_run_left;
   bit          rsp_quiet;

   route_predictor pred = new;

   sfsd_req_if req_chan ();
   sfsd_rsp_if rsp_chan ();
   sfsd_csr_if csr_chan ();

   sync_frame_steering_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned draw_gap(inout int unsigned run_left, inout bit quiet);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 40);
         quiet    = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return quiet ? 0 : $urandom_range(0, 18);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = draw_gap(req_run_left, req_quiet);
      if (req_eager)
         gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pred.take_byte(b);
   endtask

   task automatic send_frame(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
      repeat (SYNC_LEN) send_byte(SYNC_BYTE);
      send_byte(x[7:0]);
      send_byte(x[15:8]);
      send_byte(y[7:0]);
      send_byte(y[15:8]);
      send_byte(z[7:0]);
      send_byte(z[15:8]);
   endtask

   // broken sync runs or short bursts of stray bytes
   task automatic send_noise();
      int unsigned k;
      logic [7:0]  b;
      if ($urandom_range(0, 1) == 1) begin
         k = $urandom_range(1, SYNC_LEN - 1);
         repeat (k) send_byte(SYNC_BYTE);
         b = 8'($urandom_range(0, 254));
         if (b >= SYNC_BYTE)
            b = b + 8'd1;
         send_byte(b);
      end else begin
         k = $urandom_range(1, 4);
         repeat (k) begin
            b = ($urandom_range(0, 1) == 1) ? SYNC_BYTE : 8'($urandom());
            send_byte(b);
         end
      end
   endtask

   function automatic logic signed [15:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return 16'sh8000;
         1:       return -16'sd1;
         2:       return 16'sd0;
         3:       return 16'sd1;
         default: return 16'sh7FFF;
      endcase
   endfunction

   task automatic random_frames(input int unsigned n);
      logic signed [15:0] x, y, z;
      longint             sl, zl, t;
      int                 d;
      int unsigned        mode;
      repeat (n) begin
         if ($urandom_range(0, 4) == 0)
            send_noise();
         mode = $urandom_range(0, 9);
         y    = 16'($urandom());
         d    = int'($urandom_range(0, 6)) - 3;
         if (mode < 3) begin
            x = 16'($urandom());
            z = 16'($urandom());
         end else if (mode == 3) begin
            x = pick_extreme();
            y = pick_extreme();
            z = pick_extreme();
         end else if (mode < 7) begin
            // x placed within 3 of the steering threshold for this z
            z = 16'($urandom());
            if ($urandom_range(0, 3) == 0)
               z = 16'($urandom_range(0, 64)) - 16'sd32;
            sl = pred.slope;
            zl = z;
            t  = (sl * zl) / 65536;
            if ($urandom_range(0, 1) == 1)
               t = -t;
            x = 16'(t + d);
         end else begin
            z = (($urandom_range(0, 1) == 1) ? pred.far_limit : pred.near_limit) + 16'(d);
            x = 16'($urandom_range(0, 6)) - 16'sd3;
         end
         send_frame(x, y, z);
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      pred.write_reg(idx, value);
   endtask

   task automatic write_config(input logic [15:0] slope, input logic [15:0] far_lim,
                               input logic [15:0] near_lim, input bit with_spare);
      write_csr(CSR_ANGLE_SLOPE, slope);
      write_csr(CSR_FAR_LIMIT, far_lim);
      write_csr(CSR_NEAR_LIMIT, near_lim);
      if (with_spare)
         write_csr(CSR_SPARE, 16'($urandom()));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      while (pred.routes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side
   initial begin
      int unsigned gap;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_run_left, rsp_quiet);
         if (hold_request) begin
            gap          = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         pred.check_route(rsp_chan.route, rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.pos_z);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      csr_chan.valid   <= 1'b0;
      csr_chan.index   <= CSR_ANGLE_SLOPE;
      csr_chan.data    <= 16'h0000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hunt broken by a stray byte, then z = 0 frames, the first with sync bytes inside the payload
      repeat (SYNC_LEN - 1) send_byte(SYNC_BYTE);
      send_byte(8'h07);
      send_frame(16'sh7FFF, 16'sh1F1F, 16'sd0);
      send_frame(16'sh8000, 16'sh8000, 16'sd0);
      send_frame(16'sd0, 16'sh7FFF, 16'sd0);
      random_frames(PHASE_FRAMES);
      finish_phase();

      write_config(16'd0, 16'sh7FFF, 16'sh8000, 1'b1);
      random_frames(PHASE_FRAMES);
      finish_phase();

      // long result stall with the byte stream still offered
      write_config(16'hFFFF, 16'sh8000, 16'sh7FFF, 1'b0);
      hold_request = 1'b1;
      req_eager    = 1'b1;
      random_frames(PHASE_FRAMES);
      req_eager    = 1'b0;
      finish_phase();

      repeat (2) begin
         write_config(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
         random_frames(PHASE_FRAMES);
         finish_phase();
      end

      write_config(ANGLE_SLOPE_RESET, FAR_LIMIT_RESET, NEAR_LIMIT_RESET, 1'b1);
      random_frames(PHASE_FRAMES);
      finish_phase();

      repeat (20) @(posedge clock);
      if (pred.mismatches == 0 && pred.routes_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
sv/sfsd_pkg.sv
sv/sfsd_if.sv
sv/sfsd_framer.sv
sv/sfsd_route.sv
sv/sync_frame_steering_decoder.sv
sim/testbench.sv
